[rtl/core/pst_pkg.sv]
// shared types and constants of the priority session table
`timescale 1ns / 1ps
package pst_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int OUT_MAX   = 8;
    localparam int CNT_W     = 4;
    localparam int OIDX_W    = 3;

    localparam logic [31:0] STALE_AGE_RST = 32'd300000;

    localparam logic [1:0] REQ_UPSERT   = 2'd0;
    localparam logic [1:0] REQ_REMOVE   = 2'd1;
    localparam logic [1:0] REQ_SWEEP    = 2'd2;
    localparam logic [1:0] REQ_SNAPSHOT = 2'd3;

    localparam logic [1:0] ST_STALE = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] session_key;
        logic [1:0]  new_status;
        logic [63:0] sequence_req;
        logic [31:0] now_time;
        logic [3:0]  max_count;
    } req_t;

    typedef struct packed {
        logic        changed;
        logic        entry_valid;
        logic [63:0] entry_key;
        logic [1:0]  entry_status;
        logic [31:0] entry_time;
        logic [63:0] entry_sequence;
        logic [3:0]  entry_count;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [63:0] key;
        logic [1:0]  status;
        logic [31:0] tick;
        logic [63:0] seq;
    } slot_t;

endpackage

[rtl/core/priority_session_table_core.sv]
// priority session table: keyed session store with rank based eviction and sorted snapshot
`timescale 1ns / 1ps
// upsert, remove, sweep: one beat out after a scan of every slot, made one slot at a time
//   through the single read port of the entry memory
// snapshot: a scan of every slot, then per emitted beat a selection pass over the n candidates and a fetch (n <= 8)
// one request at a time; the next is taken while the final beat still waits at the output
// reset clears all slot used flags at once (no clearing pass), stale_age returns to 300000
module priority_session_table_core
    import pst_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  req_t        in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output rsp_t        out_data,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    localparam int IW = $clog2(DEPTH);

    // sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_UPD   = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_SEL   = 3'd4;
    localparam logic [2:0] S_FETCH = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    // entry memory, one read and one write port, read data registered
    slot_t          mem [DEPTH];
    slot_t          rd_q;
    logic           mem_re;
    logic [IW-1:0]  mem_ra;
    logic           mem_we;
    logic [IW-1:0]  mem_wa;
    slot_t          mem_wd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_q <= mem[mem_ra];
        end
    end

    // control state
    logic [2:0]      state_reg, state_next;
    logic [DEPTH-1:0] used_reg, used_next;
    logic [31:0]     stale_age_reg;
    req_t            req_reg, req_next;
    logic [IW:0]     rd_cnt_reg, rd_cnt_next;
    logic            ph_vld_reg, ph_vld_next;
    logic [IW-1:0]   ph_idx_reg, ph_idx_next;
    logic            chg_reg, chg_next;
    logic            out_valid_reg, out_valid_next;
    rsp_t            out_reg, out_next;

    // upsert / remove scan results
    logic            m_found_reg, m_found_next;
    logic [IW-1:0]   m_idx_reg, m_idx_next;
    logic [1:0]      m_st_reg, m_st_next;
    logic [63:0]     m_seq_reg, m_seq_next;
    logic            f_found_reg, f_found_next;
    logic [IW-1:0]   f_idx_reg, f_idx_next;
    logic [IW-1:0]   v_idx_reg, v_idx_next;
    logic [1:0]      v_st_reg, v_st_next;
    logic [31:0]     v_tm_reg, v_tm_next;

    // snapshot candidate lists
    logic [IW-1:0]   sn_idx_reg [OUT_MAX];
    logic [1:0]      sn_st_reg  [OUT_MAX];
    logic [31:0]     sn_tm_reg  [OUT_MAX];
    logic            sn_we;
    logic [OIDX_W-1:0] sn_wp;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [OUT_MAX-1:0] taken_reg, taken_next;
    logic [OIDX_W-1:0] sel_j_reg, sel_j_next;
    logic [OIDX_W-1:0] best_reg, best_next;
    logic            best_vld_reg, best_vld_next;
    logic [1:0]      best_st_reg, best_st_next;
    logic [31:0]     best_tm_reg, best_tm_next;
    logic [CNT_W-1:0] emit_reg, emit_next;

    logic            out_free;
    logic [CNT_W-1:0] lim;
    logic            scan_end;
    logic            better;
    logic            stale_seq;
    logic [IW-1:0]   tgt;
    logic [63:0]     seq_keep;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // snapshot length limit saturates at eight
    assign lim = (req_reg.max_count > CNT_W'(OUT_MAX)) ? CNT_W'(OUT_MAX) : req_reg.max_count;
    assign scan_end = ph_vld_reg && (rd_cnt_reg == (IW+1)'(DEPTH));

    // selection: lowest rank first, newest first, earliest slot on ties
    assign better = !taken_reg[sel_j_reg] &&
                    (!best_vld_reg || (sn_st_reg[sel_j_reg] < best_st_reg) ||
                     ((sn_st_reg[sel_j_reg] == best_st_reg) &&
                      (sn_tm_reg[sel_j_reg] > best_tm_reg)));

    // older sequence on an existing key is ignored
    assign stale_seq = m_found_reg && (req_reg.sequence_req != 64'd0) &&
                       (m_seq_reg != 64'd0) && (req_reg.sequence_req < m_seq_reg);
    assign tgt = m_found_reg ? m_idx_reg : (f_found_reg ? f_idx_reg : v_idx_reg);
    assign seq_keep = (req_reg.sequence_req != 64'd0) ? req_reg.sequence_req
                    : (m_found_reg ? m_seq_reg : 64'd0);

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        req_next       = req_reg;
        rd_cnt_next    = rd_cnt_reg;
        ph_vld_next    = 1'b0;
        ph_idx_next    = ph_idx_reg;
        chg_next       = chg_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        m_found_next   = m_found_reg;
        m_idx_next     = m_idx_reg;
        m_st_next      = m_st_reg;
        m_seq_next     = m_seq_reg;
        f_found_next   = f_found_reg;
        f_idx_next     = f_idx_reg;
        v_idx_next     = v_idx_reg;
        v_st_next      = v_st_reg;
        v_tm_next      = v_tm_reg;
        cnt_next       = cnt_reg;
        taken_next     = taken_reg;
        sel_j_next     = sel_j_reg;
        best_next      = best_reg;
        best_vld_next  = best_vld_reg;
        best_st_next   = best_st_reg;
        best_tm_next   = best_tm_reg;
        emit_next      = emit_reg;
        sn_we          = 1'b0;
        sn_wp          = cnt_reg[OIDX_W-1:0];
        mem_re         = 1'b0;
        mem_ra         = rd_cnt_reg[IW-1:0];
        mem_we         = 1'b0;
        mem_wa         = ph_idx_reg;
        mem_wd         = rd_q;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next     = in_data;
                    rd_cnt_next  = '0;
                    chg_next     = 1'b0;
                    m_found_next = 1'b0;
                    f_found_next = 1'b0;
                    cnt_next     = '0;
                    taken_next   = '0;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // issue one slot read a cycle
                if (rd_cnt_reg != (IW+1)'(DEPTH))
                begin
                    mem_re      = 1'b1;
                    ph_vld_next = 1'b1;
                    ph_idx_next = rd_cnt_reg[IW-1:0];
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                // look at the slot read last cycle
                if (ph_vld_reg)
                begin
                    unique case (req_reg.req_type)
                        REQ_UPSERT, REQ_REMOVE:
                        begin
                            if (used_reg[ph_idx_reg] && !m_found_reg &&
                                (rd_q.key == req_reg.session_key))
                            begin
                                m_found_next = 1'b1;
                                m_idx_next   = ph_idx_reg;
                                m_st_next    = rd_q.status;
                                m_seq_next   = rd_q.seq;
                            end
                            if (!used_reg[ph_idx_reg] && !f_found_reg)
                            begin
                                f_found_next = 1'b1;
                                f_idx_next   = ph_idx_reg;
                            end
                            if ((ph_idx_reg == '0) || (rd_q.status > v_st_reg) ||
                                ((rd_q.status == v_st_reg) && (rd_q.tick < v_tm_reg)))
                            begin
                                v_idx_next = ph_idx_reg;
                                v_st_next  = rd_q.status;
                                v_tm_next  = rd_q.tick;
                            end
                        end
                        REQ_SWEEP:
                        begin
                            if (used_reg[ph_idx_reg] && (rd_q.status != ST_STALE) &&
                                ((req_reg.now_time - rd_q.tick) >= stale_age_reg))
                            begin
                                mem_we        = 1'b1;
                                mem_wd.status = ST_STALE;
                                chg_next      = 1'b1;
                            end
                        end
                        REQ_SNAPSHOT:
                        begin
                            if (used_reg[ph_idx_reg] && (cnt_reg < lim))
                            begin
                                sn_we    = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (scan_end)
                begin
                    priority if (req_reg.req_type == REQ_SWEEP)
                        state_next = S_FIN;
                    else if (req_reg.req_type == REQ_SNAPSHOT)
                    begin
                        sel_j_next    = '0;
                        best_vld_next = 1'b0;
                        emit_next     = '0;
                        state_next    = (cnt_next == '0) ? S_FIN : S_SEL;
                    end
                    else
                        state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (req_reg.session_key != 64'd0)
                begin
                    if (req_reg.req_type == REQ_REMOVE)
                    begin
                        if (m_found_reg)
                        begin
                            used_next[m_idx_reg] = 1'b0;
                            chg_next = 1'b1;
                        end
                    end
                    else if (!stale_seq)
                    begin
                        mem_we          = 1'b1;
                        mem_wa          = tgt;
                        mem_wd.key      = req_reg.session_key;
                        mem_wd.status   = req_reg.new_status;
                        mem_wd.tick     = req_reg.now_time;
                        mem_wd.seq      = seq_keep;
                        used_next[tgt]  = 1'b1;
                        chg_next        = !m_found_reg || (m_st_reg != req_reg.new_status);
                    end
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = '0;
                    out_next.changed = chg_reg;
                    out_next.last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SEL:
            begin
                if (better)
                begin
                    best_next     = sel_j_reg;
                    best_vld_next = 1'b1;
                    best_st_next  = sn_st_reg[sel_j_reg];
                    best_tm_next  = sn_tm_reg[sel_j_reg];
                end
                sel_j_next = sel_j_reg + 1'b1;
                if ((CNT_W'(sel_j_reg) + 1'b1) == cnt_reg)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                mem_re               = 1'b1;
                mem_ra               = sn_idx_reg[best_reg];
                taken_next[best_reg] = 1'b1;
                state_next           = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.changed       = 1'b0;
                    out_next.entry_valid   = 1'b1;
                    out_next.entry_key     = rd_q.key;
                    out_next.entry_status  = rd_q.status;
                    out_next.entry_time    = rd_q.tick;
                    out_next.entry_sequence = rd_q.seq;
                    out_next.entry_count   = cnt_reg;
                    out_next.last          = ((emit_reg + 1'b1) == cnt_reg);
                    emit_next              = emit_reg + 1'b1;
                    sel_j_next             = '0;
                    best_vld_next          = 1'b0;
                    state_next = ((emit_reg + 1'b1) == cnt_reg) ? S_IDLE : S_SEL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            stale_age_reg <= STALE_AGE_RST;
            ph_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            best_vld_reg  <= 1'b0;
            taken_reg     <= '0;
            cnt_reg       <= '0;
            emit_reg      <= '0;
            rd_cnt_reg    <= '0;
            sel_j_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            ph_vld_reg    <= ph_vld_next;
            out_valid_reg <= out_valid_next;
            best_vld_reg  <= best_vld_next;
            taken_reg     <= taken_next;
            cnt_reg       <= cnt_next;
            emit_reg      <= emit_next;
            rd_cnt_reg    <= rd_cnt_next;
            sel_j_reg     <= sel_j_next;
            if (cfg_we)
            begin
                stale_age_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        ph_idx_reg   <= ph_idx_next;
        chg_reg      <= chg_next;
        out_reg      <= out_next;
        m_found_reg  <= m_found_next;
        m_idx_reg    <= m_idx_next;
        m_st_reg     <= m_st_next;
        m_seq_reg    <= m_seq_next;
        f_found_reg  <= f_found_next;
        f_idx_reg    <= f_idx_next;
        v_idx_reg    <= v_idx_next;
        v_st_reg     <= v_st_next;
        v_tm_reg     <= v_tm_next;
        best_reg     <= best_next;
        best_st_reg  <= best_st_next;
        best_tm_reg  <= best_tm_next;
        if (sn_we)
        begin
            sn_idx_reg[sn_wp] <= ph_idx_reg;
            sn_st_reg[sn_wp]  <= rd_q.status;
            sn_tm_reg[sn_wp]  <= rd_q.tick;
        end
    end

    // a snapshot beat never reports a change
    a_entry_nochg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.entry_valid |-> !out_data.changed)
        else $error("snapshot beat with changed set");

    // a beat without an entry is always the only and final one
    a_plain_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.entry_valid |-> out_data.last && out_data.entry_count == 4'd0)
        else $error("non-entry beat not final");

    // entry count stays within the snapshot limit
    a_cnt_rng: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.entry_valid |->
            out_data.entry_count != 4'd0 && out_data.entry_count <= 4'd8)
        else $error("entry count out of range");

    // the input side is closed while a request is in work
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a beat while busy");

endmodule
